// ===== sv/gwm_pkg.sv =====
// ----------------------------------------------------------------------------
// Glob wildcard matcher package
// Word types, request codes and the wildcard character codes.
// ----------------------------------------------------------------------------
package gwm_pkg;

    localparam int CH_W = 16;

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QMARK = 8'h3F;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_TEXT   = 2'd2,
        REQ_END    = 2'd3
    } t_req_type;

    typedef struct packed {
        t_req_type         req_type;
        logic [CH_W-1:0]   ch;
    } t_req_word;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } t_rsp_word;

endpackage

// ===== sv/gwm_if.sv =====
// ----------------------------------------------------------------------------
// Glob wildcard matcher channels
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
interface gwm_req_if;
    import gwm_pkg::*;

    logic      valid;
    logic      ready;
    t_req_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gwm_rsp_if;
    import gwm_pkg::*;

    logic      valid;
    logic      ready;
    t_rsp_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/glob_wildcard_matcher.sv =====
// ----------------------------------------------------------------------------
// Glob wildcard matcher
// Matches streamed text against a stored pattern with '*' and '?' wildcards.
// ----------------------------------------------------------------------------
// Usage: request words arrive on i_req. A clear word empties the pattern, an
// append word adds one pattern character, a text word advances the match by
// one character, and an end word produces one response word on o_rsp and
// rearms the matcher for the next text. Only end words produce a response.
// Each word goes into an input register and is processed from there; an end
// word's response is registered in the output register. One word is accepted
// every cycle unless stalled as below; the active position set is updated in
// a single pass per word, star runs closed by a log-depth prefix network.
// A stalled response holds in the output register; the input side keeps
// taking words until an end word meets a full output register, and then
// i_req.ready drops until o_rsp.ready frees it.
// Reset empties the pattern, clears the overflow flag and arms position zero.
// Appending past PATTERN_MAX characters sets the overflow flag, and every
// response then reads no match until the next clear.
// ----------------------------------------------------------------------------
module glob_wildcard_matcher #(
    parameter int PATTERN_MAX = 32,
    parameter int CHAR_WIDTH  = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    gwm_req_if.sink          i_req,
    gwm_rsp_if.source        o_rsp
);
    import gwm_pkg::*;

    localparam int P1      = PATTERN_MAX + 1;
    localparam int LEN_W   = $clog2(PATTERN_MAX + 1);
    localparam int STEPS   = $clog2(P1);

    localparam logic [CHAR_WIDTH-1:0] PAT_STAR  = CHAR_WIDTH'(CH_STAR);
    localparam logic [CHAR_WIDTH-1:0] PAT_QMARK = CHAR_WIDTH'(CH_QMARK);

    logic                  r_in_valid;
    t_req_word             r_in;
    logic [CHAR_WIDTH-1:0] r_pat [PATTERN_MAX];
    logic [LEN_W-1:0]      r_len;
    logic                  r_ovf;
    logic [P1-1:0]         r_act;
    logic                  r_out_valid;
    t_rsp_word             r_out;

    logic                  w_adv;
    logic                  w_in_ready;
    logic [CHAR_WIDTH-1:0] w_ch;
    logic [PATTERN_MAX-1:0] w_live;
    logic [PATTERN_MAX-1:0] w_star;
    logic [PATTERN_MAX-1:0] w_hit;
    logic [PATTERN_MAX-1:0] w_keep;
    logic [P1-1:0]         w_closed;
    logic [P1-1:0]         n_act;
    logic [LEN_W-1:0]      n_len;
    logic                  n_ovf;
    logic                  w_write;

    // Prefix network: a position is reached through a run of stars from any
    // earlier active position.
    function automatic logic [P1-1:0] close_stars(input logic [P1-1:0] g_in,
                                                   input logic [P1-1:0] p_in);
        logic [P1-1:0] g;
        logic [P1-1:0] p;
        g = g_in;
        p = p_in;
        for (int s = 0; s < STEPS; s++) begin
            g = g | (p & (g << (1 << s)));
            p = p & (p << (1 << s));
        end
        return g;
    endfunction

    assign w_adv      = r_in_valid && (r_in.req_type != REQ_END || !r_out_valid || o_rsp.ready);
    assign w_in_ready = !r_in_valid || w_adv;
    assign i_req.ready = w_in_ready;

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    assign w_ch = CHAR_WIDTH'(r_in.ch);

    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            w_live[k] = LEN_W'(k) < r_len;
            w_star[k] = w_live[k] && (r_pat[k] == PAT_STAR);
        end
    end

    assign w_closed = close_stars(r_act, {w_star, 1'b0});

    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            w_keep[k] = w_closed[k] && w_star[k];
            w_hit[k]  = w_closed[k] && w_live[k] && !w_star[k]
                        && (r_pat[k] == PAT_QMARK || r_pat[k] == w_ch);
        end
    end

    always_comb begin
        n_len   = r_len;
        n_ovf   = r_ovf;
        n_act   = P1'(1);
        w_write = 1'b0;
        unique case (r_in.req_type)
            REQ_CLEAR: begin
                n_len = '0;
                n_ovf = 1'b0;
            end
            REQ_APPEND: begin
                if (r_len < LEN_W'(PATTERN_MAX)) begin
                    w_write = 1'b1;
                    n_len   = r_len + LEN_W'(1);
                end else begin
                    n_ovf = 1'b1;
                end
            end
            REQ_TEXT: begin
                n_act = {w_hit, 1'b0} | {1'b0, w_keep};
            end
            REQ_END: begin
                n_act = P1'(1);
            end
            default: begin
                n_act = P1'(1);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_act       <= P1'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_ready) begin
                r_in_valid <= i_req.valid;
            end
            if (w_adv) begin
                r_len <= n_len;
                r_ovf <= n_ovf;
                r_act <= n_act;
            end
            if (w_adv && r_in.req_type == REQ_END) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_req.valid) begin
            r_in <= i_req.data;
        end
        if (w_adv && r_in.req_type == REQ_END) begin
            r_out.matched          <= w_closed[r_len] && !r_ovf;
            r_out.pattern_overflow <= r_ovf;
        end
        for (int k = 0; k < PATTERN_MAX; k++) begin
            if (w_adv && w_write && r_len == LEN_W'(k)) begin
                r_pat[k] <= w_ch;
            end
        end
    end

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(PATTERN_MAX))
        else $error("pattern length beyond store");

    a_rsp_from_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid && r_in.req_type == REQ_END))
        else $error("response without an end word");

    a_ovf_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.matched |-> !r_out.pattern_overflow)
        else $error("match reported with overflow");

    a_clear_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_in.req_type == REQ_CLEAR |=> r_len == '0 && !r_ovf && r_act == P1'(1))
        else $error("clear did not empty the pattern");

endmodule
